@@ rtl/cec_pkg.sv @@
`default_nettype none

package cec_pkg;

  // request codes on req_type
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_FRAME = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // result kinds on out_kind
  localparam logic [1:0] KIND_RECORD  = 2'd0;
  localparam logic [1:0] KIND_REQVOTE = 2'd1;
  localparam logic [1:0] KIND_OUTCOME = 2'd2;

  // election outcome codes
  localparam logic [1:0] OUTCOME_LEADER    = 2'd0;
  localparam logic [1:0] OUTCOME_STEP_DOWN = 2'd1;
  localparam logic [1:0] OUTCOME_TIMEOUT   = 2'd2;

  // message types
  localparam logic [7:0] FRAME_KIND_VOTE  = 8'd1;
  localparam logic [7:0] MSG_REQUEST_VOTE = 8'd0;

  // configuration register indexes
  localparam logic [1:0] CFG_NODE_ID    = 2'd0;
  localparam logic [1:0] CFG_NODE_COUNT = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT    = 2'd2;

  // configuration reset values
  localparam logic [63:0] NODE_ID_RST    = 64'd1;
  localparam logic [6:0]  NODE_COUNT_RST = 7'd3;
  localparam logic [31:0] TIMEOUT_RST    = 32'd1000;

  // work orders handed from front to back
  typedef enum logic [2:0] {
    OP_START,
    OP_START_LEAD,
    OP_STEP_DOWN,
    OP_LEADER,
    OP_TIMEOUT
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [63:0] term;
    logic [63:0] node_id;
    logic [63:0] log_idx;
  } desc_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] term;
    logic [63:0] voted_for;
    logic [63:0] sender;
    logic [63:0] log_idx;
    logic [7:0]  frame_type;
    logic [1:0]  outcome;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/cec_front.sv @@
`default_nettype none

module cec_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration writes
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [63:0]        cfg_data_i,
  // accepted request
  input  wire logic               accept_i,
  input  wire logic [1:0]         req_type_i,
  input  wire logic [63:0]        log_index_i,
  input  wire logic [63:0]        frame_term_i,
  input  wire logic [7:0]         frame_kind_i,
  input  wire logic               frame_check_ok_i,
  // descriptor toward the queue
  output logic                    push_o,
  output cec_pkg::desc_t          desc_o
);

  logic [63:0] node_id_q;
  logic [6:0]  node_count_q;
  logic [31:0] timeout_q;

  logic        camp_q, camp_d;
  logic [63:0] term_q, term_d;
  logic [63:0] voted_q, voted_d;
  logic [6:0]  votes_q, votes_d;
  logic [31:0] elapsed_q, elapsed_d;

  logic [6:0]  quorum;
  logic [6:0]  votes_inc;
  logic [31:0] elapsed_inc;
  logic        frame_ok;

  assign quorum      = {1'b0, node_count_q[6:1]} + 7'd1;
  assign votes_inc   = (votes_q == 7'h7F) ? votes_q : votes_q + 7'd1;
  assign elapsed_inc = (elapsed_q == 32'hFFFF_FFFF) ? elapsed_q : elapsed_q + 32'd1;
  assign frame_ok    = camp_q && (elapsed_q < timeout_q) && frame_check_ok_i &&
                       (frame_kind_i == cec_pkg::FRAME_KIND_VOTE);

  always_comb begin
    camp_d    = camp_q;
    term_d    = term_q;
    voted_d   = voted_q;
    votes_d   = votes_q;
    elapsed_d = elapsed_q;
    push_o    = 1'b0;
    desc_o.op      = cec_pkg::OP_START;
    desc_o.term    = term_q + 64'd1;
    desc_o.node_id = node_id_q;
    desc_o.log_idx = log_index_i;
    if (accept_i) begin
      case (req_type_i)
        cec_pkg::REQ_START: begin
          term_d    = term_q + 64'd1;
          voted_d   = node_id_q;
          votes_d   = 7'd1;
          elapsed_d = 32'd0;
          push_o    = 1'b1;
          // self vote alone may already be a majority
          if (quorum <= 7'd1) begin
            camp_d    = 1'b0;
            desc_o.op = cec_pkg::OP_START_LEAD;
          end else begin
            camp_d    = 1'b1;
          end
        end
        cec_pkg::REQ_FRAME: begin
          if (frame_ok) begin
            if (frame_term_i > term_q) begin
              term_d      = frame_term_i;
              voted_d     = 64'd0;
              camp_d      = 1'b0;
              push_o      = 1'b1;
              desc_o.op   = cec_pkg::OP_STEP_DOWN;
              desc_o.term = frame_term_i;
            end else if (frame_term_i == term_q) begin
              votes_d = votes_inc;
              if (votes_inc >= quorum) begin
                camp_d    = 1'b0;
                push_o    = 1'b1;
                desc_o.op = cec_pkg::OP_LEADER;
              end
            end
          end
        end
        cec_pkg::REQ_TICK: begin
          if (camp_q) begin
            elapsed_d = elapsed_inc;
            if (elapsed_inc >= timeout_q) begin
              camp_d    = 1'b0;
              push_o    = 1'b1;
              desc_o.op = cec_pkg::OP_TIMEOUT;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q    <= cec_pkg::NODE_ID_RST;
      node_count_q <= cec_pkg::NODE_COUNT_RST;
      timeout_q    <= cec_pkg::TIMEOUT_RST;
      camp_q       <= 1'b0;
      term_q       <= 64'd0;
      voted_q      <= 64'd0;
      votes_q      <= 7'd0;
      elapsed_q    <= 32'd0;
    end else begin
      camp_q    <= camp_d;
      term_q    <= term_d;
      voted_q   <= voted_d;
      votes_q   <= votes_d;
      elapsed_q <= elapsed_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          cec_pkg::CFG_NODE_ID:    node_id_q    <= cfg_data_i;
          cec_pkg::CFG_NODE_COUNT: node_count_q <= cfg_data_i[6:0];
          cec_pkg::CFG_TIMEOUT:    timeout_q    <= cfg_data_i[31:0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/cec_queue.sv @@
`default_nettype none

module cec_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
    next_ptr = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/cec_back.sv @@
`default_nettype none

module cec_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire cec_pkg::desc_t  desc_i,
  input  wire logic            empty_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output cec_pkg::res_t        res_o
);

  logic          out_valid_q;
  cec_pkg::res_t out_res_q;
  cec_pkg::res_t res;
  logic [1:0]    beat_q;
  logic          load;

  assign load        = !out_valid_q || out_ready_i;
  assign pop_o       = load && !empty_i && res.last;
  assign out_valid_o = out_valid_q;
  assign res_o       = out_res_q;

  // expand the head descriptor into its current result beat
  always_comb begin
    res = '0;
    case (desc_i.op)
      cec_pkg::OP_START, cec_pkg::OP_START_LEAD: begin
        case (beat_q)
          2'd0: begin
            res.kind      = cec_pkg::KIND_RECORD;
            res.term      = desc_i.term;
            res.voted_for = desc_i.node_id;
          end
          2'd1: begin
            res.kind       = cec_pkg::KIND_REQVOTE;
            res.term       = desc_i.term;
            res.sender     = desc_i.node_id;
            res.log_idx    = desc_i.log_idx;
            res.frame_type = cec_pkg::MSG_REQUEST_VOTE;
            res.last       = (desc_i.op == cec_pkg::OP_START);
          end
          default: begin
            res.kind    = cec_pkg::KIND_OUTCOME;
            res.outcome = cec_pkg::OUTCOME_LEADER;
            res.last    = 1'b1;
          end
        endcase
      end
      cec_pkg::OP_STEP_DOWN: begin
        if (beat_q == 2'd0) begin
          res.kind = cec_pkg::KIND_RECORD;
          res.term = desc_i.term;
        end else begin
          res.kind    = cec_pkg::KIND_OUTCOME;
          res.outcome = cec_pkg::OUTCOME_STEP_DOWN;
          res.last    = 1'b1;
        end
      end
      cec_pkg::OP_LEADER: begin
        res.kind    = cec_pkg::KIND_OUTCOME;
        res.outcome = cec_pkg::OUTCOME_LEADER;
        res.last    = 1'b1;
      end
      default: begin
        res.kind    = cec_pkg::KIND_OUTCOME;
        res.outcome = cec_pkg::OUTCOME_TIMEOUT;
        res.last    = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load && !empty_i) begin
      out_res_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      beat_q      <= 2'd0;
    end else if (load) begin
      out_valid_q <= !empty_i;
      if (!empty_i) begin
        beat_q <= res.last ? 2'd0 : beat_q + 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/consensus_election_candidate_unit.sv @@
// Candidate side of a leader election.
// Input channel (in_valid_i / in_ready_o): one beat per request: start an
// election, a received frame, or one timer tick. The front end updates the
// term, vote and timeout state in the cycle the beat is taken and queues a
// descriptor of the results it causes; requests that cause none queue nothing.
// Output channel (out_valid_o / out_ready_i): one beat per result, last_o
// marks the final result of a request. A start gives two or three beats, a
// step-down two, a leader or timeout outcome one.
// The first result of a request passes through the descriptor queue and then
// the output register. One request per cycle is taken while the queue is not
// full; the output register sends one result per cycle with out_ready_i high.
// Stall: while the receiver holds out_ready_i low, the queue of QUEUE_DEPTH
// descriptors keeps taking requests; in_ready_o drops only when it is full.
// Configuration (cfg_valid_i / cfg_ready_o) is always ready and is to be
// written only while the block is idle.
// Reset: clears the election state and the queue, restores node id 1, three
// nodes and a 1000 tick timeout; no output beat is pending afterward.
`default_nettype none

module consensus_election_candidate_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  // requests
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [63:0] log_index_i,
  input  wire logic [63:0] frame_term_i,
  input  wire logic [7:0]  frame_kind_i,
  input  wire logic        frame_check_ok_i,
  // results
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       out_kind_o,
  output logic [63:0]      out_term_o,
  output logic [63:0]      out_voted_for_o,
  output logic [63:0]      out_sender_o,
  output logic [63:0]      out_last_index_o,
  output logic [7:0]       out_msg_type_o,
  output logic [1:0]       outcome_o,
  output logic             last_o
);

  localparam int DescW = $bits(cec_pkg::desc_t);

  logic           q_full, q_empty, q_push, q_pop;
  cec_pkg::desc_t push_desc, head_desc;
  cec_pkg::res_t  res;
  logic           accept;

  assign cfg_ready_o = 1'b1;
  // hold requests only while the descriptor queue is full
  assign in_ready_o  = !q_full;
  assign accept      = in_valid_i && in_ready_o;

  cec_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .accept_i         (accept),
    .req_type_i       (req_type_i),
    .log_index_i      (log_index_i),
    .frame_term_i     (frame_term_i),
    .frame_kind_i     (frame_kind_i),
    .frame_check_ok_i (frame_check_ok_i),
    .push_o           (q_push),
    .desc_o           (push_desc)
  );

  cec_queue #(
    .WIDTH (DescW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (push_desc),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (head_desc),
    .empty_o (q_empty)
  );

  cec_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .desc_i      (head_desc),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  // drive result fields from the output register
  assign out_kind_o       = res.kind;
  assign out_term_o       = res.term;
  assign out_voted_for_o  = res.voted_for;
  assign out_sender_o     = res.sender;
  assign out_last_index_o = res.log_idx;
  assign out_msg_type_o   = res.frame_type;
  assign outcome_o        = res.outcome;
  assign last_o           = res.last;

endmodule

`default_nettype wire
